FILE: rtl/sler_pkg.sv
// Shared types, codes and constants of the serial line editor ring.
`timescale 1ns / 1ps
`default_nettype none

package sler_pkg;

  localparam int SLOTS_DEF      = 32;
  localparam int LINE_BYTES_DEF = 32;

  localparam logic [7:0] CODE_ESC      = 8'h1B;
  localparam logic [7:0] CODE_LBRACKET = 8'h5B;
  localparam logic [7:0] CODE_UPKEY    = 8'h41;
  localparam logic [7:0] CODE_LF       = 8'h0A;
  localparam logic [7:0] CODE_CR       = 8'h0D;
  localparam logic [7:0] CODE_SPACE    = 8'h20;
  localparam logic [7:0] BS_RESET      = 8'h08;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // What a pushed result carries
  typedef enum logic [3:0] {
    EM_RX    = 4'd0,
    EM_CR    = 4'd1,
    EM_LF    = 4'd2,
    EM_SPACE = 4'd3,
    EM_BS    = 4'd4,
    EM_HDR   = 4'd5,
    EM_COPY  = 4'd6,
    EM_LINE  = 4'd7,
    EM_EMPTY = 4'd8,
    EM_NONE  = 4'd9
  } emit_t;

  typedef enum logic [1:0] {
    RD_CUR0 = 2'd0,
    RD_CUR1 = 2'd1,
    RD_SRC  = 2'd2,
    RD_POP  = 2'd3
  } rd_sel_t;

  typedef enum logic [1:0] {
    TW_NONE = 2'd0,
    TW_RX   = 2'd1,
    TW_ZERO = 2'd2,
    TW_COPY = 2'd3
  } txt_wr_t;

  typedef enum logic [2:0] {
    FW_NONE    = 3'd0,
    FW_INC     = 3'd1,
    FW_DEC     = 3'd2,
    FW_ZERO_RD = 3'd3,
    FW_IDX     = 3'd4,
    FW_IDX1    = 3'd5
  } fill_wr_t;

  typedef enum logic [1:0] {
    IX_HOLD  = 2'd0,
    IX_CLEAR = 2'd1,
    IX_INC   = 2'd2
  } idx_op_t;

  typedef struct packed {
    logic     latch;
    logic     clr_step;
    logic     push_en;
    emit_t    emit;
    logic     finish;
    rd_sel_t  rd_sel;
    txt_wr_t  txt_wr;
    fill_wr_t fill_wr;
    idx_op_t  idx_op;
    logic     esc_cap;
    logic     adv_ws;
    logic     adv_rs;
  } sler_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic func;
    logic is_crlf;
    logic is_bs;
    logic fill_zero;
    logic fill_room;
    logic fill_two;
    logic ptr_eq;
    logic rd_zero;
    logic esc_hit;
    logic hdr_end;
    logic copy_end;
    logic pop_end;
  } sler_sts_t;

endpackage

`default_nettype wire

FILE: rtl/sler_dp.sv
// Datapath of the line editor: line and fill memories, pointers, result staging.
`timescale 1ns / 1ps
`default_nettype none

module sler_dp import sler_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sler_cmd_t  cmd,
  output sler_sts_t       sts,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  output logic            out_strobe,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  localparam int TXT_DEPTH = SLOTS * LINE_BYTES;
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(LINE_BYTES);
  localparam int AW = $clog2(TXT_DEPTH);

  logic [7:0]    txt_mem [TXT_DEPTH];
  logic [LW-1:0] fill_mem [SLOTS];

  logic [7:0]    txt_q_r;
  logic [LW-1:0] fill_q_r;
  logic [AW-1:0] clr_cnt_r;
  logic [SW-1:0] ws_r, rs_r;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          func_r;
  logic [7:0]    rx_r;
  logic [7:0]    bs_r;
  logic          esc0_r;

  logic          pend_v_r, pend_v_nxt;
  kind_t         pend_kind_r, pend_kind_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;

  logic          out_strobe_r, out_strobe_nxt;
  kind_t         out_kind_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic [SW-1:0] src_slot;
  logic [AW-1:0] txt_ra, txt_wa;
  logic [7:0]    txt_wd;
  logic          txt_we;
  logic [SW-1:0] fill_wa;
  logic [LW-1:0] fill_wd;
  logic          fill_we;

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s, input logic [LW-1:0] p);
    return AW'(s) * AW'(LINE_BYTES) + AW'(p);
  endfunction

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(SLOTS - 1)) ? '0 : SW'(s + SW'(1));
  endfunction

  assign src_slot = (ws_r == '0) ? SW'(SLOTS - 1) : SW'(ws_r - SW'(1));

  always_comb begin
    case (cmd.idx_op)
      IX_CLEAR: idx_nxt = '0;
      IX_INC:   idx_nxt = LW'(idx_r + LW'(1));
      default:  idx_nxt = idx_r;
    endcase
  end

  // Text memory: one write port, one registered read port
  always_comb begin
    case (cmd.rd_sel)
      RD_CUR0: txt_ra = slot_addr(ws_r, '0);
      RD_CUR1: txt_ra = slot_addr(ws_r, LW'(1));
      RD_SRC:  txt_ra = slot_addr(src_slot, idx_nxt);
      RD_POP:  txt_ra = slot_addr(rs_r, idx_nxt);
      default: txt_ra = '0;
    endcase
  end

  always_comb begin
    txt_we = 1'b0;
    txt_wa = '0;
    txt_wd = '0;
    if (cmd.clr_step) begin
      txt_we = 1'b1;
      txt_wa = clr_cnt_r;
    end else begin
      case (cmd.txt_wr)
        TW_RX: begin
          txt_we = 1'b1;
          txt_wa = slot_addr(ws_r, fill_q_r);
          txt_wd = rx_r;
        end
        TW_ZERO: begin
          txt_we = 1'b1;
          txt_wa = slot_addr(ws_r, fill_q_r);
        end
        TW_COPY: begin
          txt_we = 1'b1;
          txt_wa = slot_addr(ws_r, idx_r);
          txt_wd = txt_q_r;
        end
        default: txt_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (txt_we) txt_mem[txt_wa] <= txt_wd;
    txt_q_r <= txt_mem[txt_ra];
  end

  // Fill memory
  always_comb begin
    fill_we = 1'b0;
    fill_wa = ws_r;
    fill_wd = '0;
    if (cmd.clr_step) begin
      fill_we = (clr_cnt_r < AW'(SLOTS));
      fill_wa = clr_cnt_r[SW-1:0];
    end else begin
      case (cmd.fill_wr)
        FW_INC: begin
          fill_we = 1'b1;
          fill_wd = LW'(fill_q_r + LW'(1));
        end
        FW_DEC: begin
          fill_we = 1'b1;
          fill_wd = LW'(fill_q_r - LW'(1));
        end
        FW_ZERO_RD: begin
          fill_we = 1'b1;
          fill_wa = rs_r;
        end
        FW_IDX: begin
          fill_we = 1'b1;
          fill_wd = idx_r;
        end
        FW_IDX1: begin
          fill_we = 1'b1;
          fill_wd = LW'(idx_r + LW'(1));
        end
        default: fill_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    fill_q_r <= fill_mem[func_r ? rs_r : ws_r];
  end

  // Pointers, item registers, configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      ws_r      <= '0;
      rs_r      <= '0;
      func_r    <= 1'b0;
      bs_r      <= BS_RESET;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= AW'(clr_cnt_r + AW'(1));
      if (cmd.adv_ws)   ws_r <= next_slot(ws_r);
      if (cmd.adv_rs)   rs_r <= next_slot(rs_r);
      if (cmd.latch)    func_r <= in_func;
      if (cfg_wr_en)    bs_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch)   rx_r <= in_rx_byte;
    if (cmd.esc_cap) esc0_r <= (txt_q_r == CODE_ESC);
  end

  // Result staging: a pushed result waits in pend until the next push or the finish,
  // so the last flag is known when it leaves
  always_comb begin
    pend_kind_nxt = pend_kind_r;
    pend_byte_nxt = pend_byte_r;
    if (cmd.push_en) begin
      case (cmd.emit)
        EM_RX:    begin pend_kind_nxt = KIND_ECHO;  pend_byte_nxt = rx_r;       end
        EM_CR:    begin pend_kind_nxt = KIND_ECHO;  pend_byte_nxt = CODE_CR;    end
        EM_LF:    begin pend_kind_nxt = KIND_ECHO;  pend_byte_nxt = CODE_LF;    end
        EM_SPACE: begin pend_kind_nxt = KIND_ECHO;  pend_byte_nxt = CODE_SPACE; end
        EM_BS:    begin pend_kind_nxt = KIND_ECHO;  pend_byte_nxt = bs_r;       end
        EM_HDR: begin
          pend_kind_nxt = KIND_ECHO;
          pend_byte_nxt = idx_r[0] ? CODE_LF : CODE_CR;
        end
        EM_COPY:  begin pend_kind_nxt = KIND_ECHO;  pend_byte_nxt = txt_q_r;    end
        EM_LINE:  begin pend_kind_nxt = KIND_LINE;  pend_byte_nxt = txt_q_r;    end
        EM_EMPTY: begin pend_kind_nxt = KIND_EMPTY; pend_byte_nxt = '0;         end
        EM_NONE:  begin pend_kind_nxt = KIND_NONE;  pend_byte_nxt = '0;         end
        default:  begin pend_kind_nxt = KIND_ECHO;  pend_byte_nxt = '0;         end
      endcase
    end
    if (cmd.push_en)     pend_v_nxt = 1'b1;
    else if (cmd.finish) pend_v_nxt = 1'b0;
    else                 pend_v_nxt = pend_v_r;
    out_strobe_nxt = pend_v_r & (cmd.push_en | cmd.finish);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pend_byte_r <= pend_byte_nxt;
    if (out_strobe_nxt) begin
      out_kind_r <= pend_kind_r;
      out_byte_r <= pend_byte_r;
      out_last_r <= cmd.finish;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_kind   = out_kind_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  // Status
  always_comb begin
    sts.clr_last  = (clr_cnt_r == AW'(TXT_DEPTH - 1));
    sts.func      = func_r;
    sts.is_crlf   = (rx_r == CODE_CR) || (rx_r == CODE_LF);
    sts.is_bs     = (rx_r == bs_r);
    sts.fill_zero = (fill_q_r == '0);
    sts.fill_room = (fill_q_r < LW'(LINE_BYTES - 1));
    sts.fill_two  = (fill_q_r == LW'(2));
    sts.ptr_eq    = (rs_r == ws_r);
    sts.rd_zero   = (txt_q_r == '0);
    sts.esc_hit   = esc0_r && (txt_q_r == CODE_LBRACKET) && (rx_r == CODE_UPKEY);
    sts.hdr_end   = (idx_r == LW'(3));
    sts.copy_end  = (idx_r == LW'(LINE_BYTES - 2));
    sts.pop_end   = (LW'(idx_r + LW'(1)) == fill_q_r);
  end

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_last_r |=> !out_strobe_r)
    else $error("result beat straight after a closing beat");

  a_strobe_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(pend_v_r))
    else $error("result beat without a staged result");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, ws_r} < (SW + 1)'(SLOTS)) && ({1'b0, rs_r} < (SW + 1)'(SLOTS)))
    else $error("slot pointer beyond the ring");

  a_idx_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_en && cmd.emit == EM_LINE |-> idx_r < fill_q_r)
    else $error("pop reads beyond the line fill");

endmodule

`default_nettype wire

FILE: rtl/sler_ctrl.sv
// Controller state machine of the line editor.
`timescale 1ns / 1ps
`default_nettype none

module sler_ctrl import sler_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire sler_sts_t sts,
  output sler_cmd_t      cmd
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_LOOKUP   = 13'b0000000000100,
    S_DECIDE   = 13'b0000000001000,
    S_ENDL     = 13'b0000000010000,
    S_BS1      = 13'b0000000100000,
    S_BS2      = 13'b0000001000000,
    S_CHK0     = 13'b0000010000000,
    S_CHK1     = 13'b0000100000000,
    S_REC_HDR  = 13'b0001000000000,
    S_REC_COPY = 13'b0010000000000,
    S_POP_COPY = 13'b0100000000000,
    S_FINISH   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.push_en = 1'b1;
        if (sts.func) begin
          if (sts.ptr_eq) begin
            cmd.emit  = EM_NONE;
            state_nxt = S_FINISH;
          end else if (sts.fill_zero) begin
            cmd.emit    = EM_EMPTY;
            cmd.fill_wr = FW_ZERO_RD;
            cmd.adv_rs  = 1'b1;
            state_nxt   = S_FINISH;
          end else begin
            cmd.push_en = 1'b0;
            cmd.idx_op  = IX_CLEAR;
            cmd.rd_sel  = RD_POP;
            state_nxt   = S_POP_COPY;
          end
        end else if (sts.is_crlf) begin
          cmd.emit   = EM_CR;
          cmd.txt_wr = TW_ZERO;
          cmd.adv_ws = 1'b1;
          state_nxt  = S_ENDL;
        end else begin
          cmd.emit = EM_RX;
          if (sts.is_bs) begin
            state_nxt = sts.fill_zero ? S_FINISH : S_BS1;
          end else if (sts.fill_room) begin
            cmd.txt_wr  = TW_RX;
            cmd.fill_wr = FW_INC;
            if (sts.fill_two) begin
              cmd.rd_sel = RD_CUR0;
              state_nxt  = S_CHK0;
            end else begin
              state_nxt = S_FINISH;
            end
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_ENDL: begin
        cmd.push_en = 1'b1;
        cmd.emit    = EM_LF;
        state_nxt   = S_FINISH;
      end
      S_BS1: begin
        cmd.push_en = 1'b1;
        cmd.emit    = EM_SPACE;
        state_nxt   = S_BS2;
      end
      S_BS2: begin
        cmd.push_en = 1'b1;
        cmd.emit    = EM_BS;
        cmd.fill_wr = FW_DEC;
        state_nxt   = S_FINISH;
      end
      S_CHK0: begin
        cmd.esc_cap = 1'b1;
        cmd.rd_sel  = RD_CUR1;
        state_nxt   = S_CHK1;
      end
      S_CHK1: begin
        if (sts.esc_hit) begin
          cmd.idx_op = IX_CLEAR;
          state_nxt  = S_REC_HDR;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_REC_HDR: begin
        cmd.push_en = 1'b1;
        cmd.emit    = EM_HDR;
        if (sts.hdr_end) begin
          cmd.idx_op = IX_CLEAR;
          cmd.rd_sel = RD_SRC;
          state_nxt  = S_REC_COPY;
        end else begin
          cmd.idx_op = IX_INC;
        end
      end
      S_REC_COPY: begin
        if (sts.rd_zero) begin
          cmd.fill_wr = FW_IDX;
          state_nxt   = S_FINISH;
        end else begin
          cmd.push_en = 1'b1;
          cmd.emit    = EM_COPY;
          cmd.txt_wr  = TW_COPY;
          if (sts.copy_end) begin
            cmd.fill_wr = FW_IDX1;
            state_nxt   = S_FINISH;
          end else begin
            cmd.idx_op = IX_INC;
            cmd.rd_sel = RD_SRC;
          end
        end
      end
      S_POP_COPY: begin
        cmd.push_en = 1'b1;
        cmd.emit    = EM_LINE;
        if (sts.pop_end) begin
          cmd.fill_wr = FW_ZERO_RD;
          cmd.adv_rs  = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.idx_op = IX_INC;
          cmd.rd_sel = RD_POP;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cmd.push_en && !cmd.finish && cmd.txt_wr == TW_NONE)
    else $error("datapath commanded while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

endmodule

`default_nettype wire

FILE: rtl/serial_line_editor_ring_unit.sv
// Top level of the serial line editor ring: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Serial line editor with a ring of SLOTS line slots of LINE_BYTES bytes each.
// Pulse start while busy is low to hand over one beat: in_func = 0 carries a
// received byte in in_rx_byte, in_func = 1 pops the oldest completed line.
// Every beat yields one or more results, each shown on out_kind, out_byte and
// out_last for exactly one cycle with out_strobe high; the receiver must take
// every result as it comes, there is no way to hold results off. out_last
// marks the final result of a beat. Results follow one per cycle for pops and
// recall copies. Storing the third character of a line reads the first two
// back to look for the recall keys; a recall copies at most LINE_BYTES - 1
// bytes. The line memory has one read and one write port and is walked one
// byte a cycle; that walk sets the rate.
// After reset the block clears its line and fill memories, one entry a
// cycle, over all SLOTS * LINE_BYTES line entries (1024 at the defaults),
// with busy held high. cfg_wr_en / cfg_wr_data set the backspace code
// (reset 0x08); write it only while busy is low and no results are still due.

module serial_line_editor_ring_unit import sler_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  output logic            out_strobe,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  sler_cmd_t cmd;
  sler_sts_t sts;

  // Sequence each beat: lookup fill, decide, walk memory, close the result run
  sler_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hold the line text, fills and pointers; stage results for the output
  sler_dp #(
    .SLOTS      (SLOTS),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_func     (in_func),
    .in_rx_byte  (in_rx_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_strobe  (out_strobe),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

FILE: bench/tb_serial_line_editor_ring_unit.sv
// Self-checking testbench for the serial line editor ring: directed table, then random phases.
`timescale 1ns / 1ps

module tb_serial_line_editor_ring_unit;
  import sler_pkg::*;

  localparam int SL = SLOTS_DEF;
  localparam int LB = LINE_BYTES_DEF;

  // Request codes on in_func
  localparam logic FN_BYTE = 1'b0;
  localparam logic FN_POP  = 1'b1;

  // Quiet cycles allowed after the last result before the block is touched again
  localparam int DRAIN_CYCLES = 8;
  localparam int BEATS_PER_PHASE = 55;

  // Per phase: backspace key and sender idle percentage. Index 0 is the rightmost entry.
  localparam logic [5:0][7:0] PHASE_KEY  = {BS_RESET, CODE_LF, CODE_CR, 8'hFF, 8'h00, 8'h7F};
  localparam logic [5:0][6:0] PHASE_IDLE = {7'd0, 7'd55, 7'd35, 7'd0, 7'd55, 7'd0};

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // One directed row; typed[i] = {kind, byte}, used only when n_typed is non-zero
  typedef struct packed {
    logic            func;
    logic [7:0]      rx;
    logic [1:0]      n_typed;
    logic [2:0][9:0] typed;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_func = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       out_strobe;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  // Shadow of the editor state, kept in step with every accepted beat
  logic [7:0] ln_text [SL][LB];
  int         ln_fill [SL];
  int         wr_slot;
  int         rd_slot;
  logic [7:0] bs_key;

  out_beat_t  step_out [$];   // results of the beat being predicted
  out_beat_t  due_out [$];    // results still owed by the block, oldest first
  int         mismatches = 0;
  int         beats_sent = 0;
  int         idle_pct = 0;

  serial_line_editor_ring_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_rx_byte  (in_rx_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_strobe  (out_strobe),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t ns: MISMATCH %s", $time, what);
  endtask

  task automatic emit(input kind_t k, input logic [7:0] b);
    step_out.push_back('{kind: k, data: b, last: 1'b0});
  endtask

  // Work out the results of one beat and advance the shadow state
  task automatic editor_predict(input logic f, input logic [7:0] rx);
    int fill;
    int src;
    int i;
    logic [7:0] c;
    step_out.delete();
    fill = ln_fill[wr_slot];
    if (f == FN_POP) begin
      // Equal pointers: nothing pending, even if the ring has wrapped
      if (rd_slot == wr_slot) begin
        emit(KIND_NONE, 8'h00);
      end else begin
        if (ln_fill[rd_slot] == 0) begin
          emit(KIND_EMPTY, 8'h00);
        end else begin
          for (i = 0; i < ln_fill[rd_slot] && i < LB - 1; i++)
            emit(KIND_LINE, ln_text[rd_slot][i]);
        end
        ln_fill[rd_slot] = 0;
        rd_slot = (rd_slot + 1) % SL;
      end
    end else if (rx == CODE_LF || rx == CODE_CR) begin
      // Line end wins over a backspace key set to CR or LF
      emit(KIND_ECHO, CODE_CR);
      emit(KIND_ECHO, CODE_LF);
      if (fill > LB - 1) fill = LB - 1;
      ln_text[wr_slot][fill] = 8'h00;
      wr_slot = (wr_slot + 1) % SL;
    end else begin
      emit(KIND_ECHO, rx);
      if (rx == bs_key) begin
        // Rub-out only when there is something to remove
        if (fill != 0) begin
          emit(KIND_ECHO, CODE_SPACE);
          emit(KIND_ECHO, bs_key);
          ln_fill[wr_slot] = fill - 1;
        end
      end else if (fill < LB - 1) begin
        // A full line drops the byte and skips the recall check
        ln_text[wr_slot][fill] = rx;
        fill++;
        ln_fill[wr_slot] = fill;
        if (fill == 3 && ln_text[wr_slot][0] == CODE_ESC &&
            ln_text[wr_slot][1] == CODE_LBRACKET && ln_text[wr_slot][2] == CODE_UPKEY) begin
          src = (wr_slot + SL - 1) % SL;
          emit(KIND_ECHO, CODE_CR);
          emit(KIND_ECHO, CODE_LF);
          emit(KIND_ECHO, CODE_CR);
          emit(KIND_ECHO, CODE_LF);
          // Copy up to the first zero byte, or LB-1 bytes if there is none
          for (i = 0; i < LB - 1; i++) begin
            c = ln_text[src][i];
            if (c == 8'h00) break;
            ln_text[wr_slot][i] = c;
            emit(KIND_ECHO, c);
          end
          ln_fill[wr_slot] = i;
        end
      end
    end
    step_out[step_out.size() - 1].last = 1'b1;
  endtask

  // Offer one beat, hold it until accepted, then queue what it owes
  task automatic send_beat(input logic f, input logic [7:0] rx, input logic [1:0] n_typed,
                           input logic [2:0][9:0] typed);
    int i;
    // Sender gaps: each cycle idle with the phase's odds
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    in_func    <= f;
    in_rx_byte <= rx;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    editor_predict(f, rx);
    if (n_typed == 0) begin
      foreach (step_out[i]) due_out.push_back(step_out[i]);
    end else begin
      // Hand-written expectation replaces the shadow's for this row
      for (i = 0; i < n_typed; i++)
        due_out.push_back('{kind: kind_t'(typed[i][9:8]), data: typed[i][7:0],
                            last: (i == n_typed - 1)});
    end
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_beat(FN_BYTE, rx, 2'd0, '0);
  endtask

  // Drop start and wait until the block owes nothing and has settled
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (due_out.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_bs_key(input logic [7:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    bs_key = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Text byte for a line: mostly anything but a line end, now and then the rub-out key
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CODE_CR || b == CODE_LF) b = 8'($urandom_range(32, 126));
    if ($urandom_range(7) == 0) b = bs_key;
    return b;
  endfunction

  function automatic logic [7:0] pick_line_end();
    return ($urandom_range(1) != 0) ? CODE_CR : CODE_LF;
  endfunction

  // One random sequence: mostly well-formed lines, recalls and pops, some noise
  task automatic random_burst(input bit flood_ok, inout bit flooded);
    int roll;
    int len;
    roll = $urandom_range(99);
    if (flood_ok && !flooded && roll < 4) begin
      // Run the write pointer round the ring past the read pointer
      flooded = 1'b1;
      repeat ($urandom_range(30, 36)) send_byte(pick_line_end());
    end else if (roll < 42) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
      repeat (len) send_byte(pick_text_byte());
      send_byte(pick_line_end());
      // Recall straight after a long line to copy a line with no terminator
      if (len >= 28 && $urandom_range(1) != 0) begin
        send_byte(CODE_ESC);
        send_byte(CODE_LBRACKET);
        send_byte(CODE_UPKEY);
        send_byte(pick_line_end());
      end
    end else if (roll < 58) begin
      send_byte(CODE_ESC);
      send_byte(CODE_LBRACKET);
      if ($urandom_range(3) == 0) begin
        send_byte(bs_key);
        send_byte(CODE_LBRACKET);
      end
      send_byte(CODE_UPKEY);
      repeat ($urandom_range(3)) send_byte(pick_text_byte());
      send_byte(pick_line_end());
    end else if (roll < 66) begin
      // Near misses of the recall key sequence
      case ($urandom_range(2))
        0: begin
          send_byte(CODE_ESC);
          send_byte(CODE_LBRACKET);
          send_byte(8'($urandom_range(255)));
        end
        1: begin
          send_byte(CODE_ESC);
          send_byte(8'($urandom_range(255)));
          send_byte(CODE_UPKEY);
        end
        default: begin
          send_byte(8'($urandom_range(32, 126)));
          send_byte(CODE_ESC);
          send_byte(CODE_LBRACKET);
          send_byte(CODE_UPKEY);
        end
      endcase
      send_byte(pick_line_end());
    end else if (roll < 90) begin
      repeat ($urandom_range(1, 3)) send_beat(FN_POP, 8'($urandom_range(255)), 2'd0, '0);
    end else begin
      send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 2'd0, '0);
    end
  endtask

  // Result checker: the receiver cannot stall, so every strobe is taken as it comes
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (due_out.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                out_kind, out_byte, out_last));
      end else begin
        want = due_out.pop_front();
        if (out_kind !== want.kind || out_byte !== want.data || out_last !== want.last)
          flag_mismatch($sformatf("got kind %0d byte %02h last %0b, want %0d %02h %0b",
                                  out_kind, out_byte, out_last,
                                  want.kind, want.data, want.last));
      end
    end
  end

  // Hard stop in case the block hangs or results go missing
  initial begin
    #1_000_000;
    $display("tb_serial_line_editor_ring_unit NOT OK");
    $finish;
  end

  function automatic plan_row_t plan_entry(input logic f, input logic [7:0] rx,
                                           input logic [1:0] n, input logic [9:0] t0,
                                           input logic [9:0] t1, input logic [9:0] t2);
    plan_entry.func    = f;
    plan_entry.rx      = rx;
    plan_entry.n_typed = n;
    plan_entry.typed   = {t2, t1, t0};
  endfunction

  initial begin
    plan_row_t plan_tbl [23];
    int r;
    int p;
    int target;
    int guard;
    bit paused;
    bit flooded;

    // Shadow state after reset
    for (r = 0; r < SL; r++) begin
      ln_fill[r] = 0;
      for (p = 0; p < LB; p++) ln_text[r][p] = 8'h00;
    end
    wr_slot = 0;
    rd_slot = 0;
    bs_key  = BS_RESET;

    // Directed rows; zero count means the shadow supplies the expectation
    plan_tbl[0]  = plan_entry(FN_POP,  8'h00, 1, {KIND_NONE, 8'h00}, '0, '0);
    plan_tbl[1]  = plan_entry(FN_BYTE, BS_RESET, 1, {KIND_ECHO, BS_RESET}, '0, '0);
    plan_tbl[2]  = plan_entry(FN_BYTE, 8'h61, 1, {KIND_ECHO, 8'h61}, '0, '0);
    plan_tbl[3]  = plan_entry(FN_BYTE, BS_RESET, 3, {KIND_ECHO, BS_RESET},
                              {KIND_ECHO, CODE_SPACE}, {KIND_ECHO, BS_RESET});
    plan_tbl[4]  = plan_entry(FN_BYTE, CODE_CR, 2, {KIND_ECHO, CODE_CR},
                              {KIND_ECHO, CODE_LF}, '0);
    plan_tbl[5]  = plan_entry(FN_POP,  8'h00, 1, {KIND_EMPTY, 8'h00}, '0, '0);
    plan_tbl[6]  = plan_entry(FN_BYTE, 8'hFF, 1, {KIND_ECHO, 8'hFF}, '0, '0);
    plan_tbl[7]  = plan_entry(FN_BYTE, 8'h00, 1, {KIND_ECHO, 8'h00}, '0, '0);
    plan_tbl[8]  = plan_entry(FN_BYTE, CODE_UPKEY, 1, {KIND_ECHO, CODE_UPKEY}, '0, '0);
    plan_tbl[9]  = plan_entry(FN_BYTE, CODE_LF, 2, {KIND_ECHO, CODE_CR},
                              {KIND_ECHO, CODE_LF}, '0);
    plan_tbl[10] = plan_entry(FN_BYTE, CODE_ESC, 1, {KIND_ECHO, CODE_ESC}, '0, '0);
    plan_tbl[11] = plan_entry(FN_BYTE, CODE_LBRACKET, 1, {KIND_ECHO, CODE_LBRACKET}, '0, '0);
    // Recall: the source line holds a zero byte, so the copy stops there
    plan_tbl[12] = plan_entry(FN_BYTE, CODE_UPKEY, 0, '0, '0, '0);
    plan_tbl[13] = plan_entry(FN_BYTE, CODE_CR, 2, {KIND_ECHO, CODE_CR},
                              {KIND_ECHO, CODE_LF}, '0);
    plan_tbl[14] = plan_entry(FN_POP,  8'h00, 0, '0, '0, '0);
    plan_tbl[15] = plan_entry(FN_POP,  8'h00, 0, '0, '0, '0);
    plan_tbl[16] = plan_entry(FN_POP,  8'h00, 1, {KIND_NONE, 8'h00}, '0, '0);
    // Broken recall key sequence is stored as plain text
    plan_tbl[17] = plan_entry(FN_BYTE, CODE_ESC, 1, {KIND_ECHO, CODE_ESC}, '0, '0);
    plan_tbl[18] = plan_entry(FN_BYTE, CODE_LBRACKET, 1, {KIND_ECHO, CODE_LBRACKET}, '0, '0);
    plan_tbl[19] = plan_entry(FN_BYTE, 8'h42, 1, {KIND_ECHO, 8'h42}, '0, '0);
    plan_tbl[20] = plan_entry(FN_BYTE, CODE_CR, 2, {KIND_ECHO, CODE_CR},
                              {KIND_ECHO, CODE_LF}, '0);
    plan_tbl[21] = plan_entry(FN_POP,  8'h00, 0, '0, '0, '0);
    // Pop ignores the byte field
    plan_tbl[22] = plan_entry(FN_POP,  8'hFF, 1, {KIND_NONE, 8'h00}, '0, '0);

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Waits out the clearing pass, then writes the reset key explicitly
    set_bs_key(BS_RESET);

    idle_pct = 0;
    for (r = 0; r < 23; r++)
      send_beat(plan_tbl[r].func, plan_tbl[r].rx, plan_tbl[r].n_typed, plan_tbl[r].typed);

    // Random phases, each with its own backspace key and sender idling
    paused = 1'b0;
    for (p = 0; p < 6; p++) begin
      set_bs_key(PHASE_KEY[p]);
      idle_pct = PHASE_IDLE[p];
      target   = beats_sent + BEATS_PER_PHASE;
      flooded  = 1'b0;
      while (beats_sent < target) begin
        random_burst(p == 2 || p == 4, flooded);
        // Hold the sender once mid-way through phase 1 until the block owes nothing
        if (p == 1 && !paused && beats_sent >= target - 25) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    // Drain: bounded wait for the last results, then a short settle
    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while ((due_out.size() != 0 || busy) && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_out.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", due_out.size()));

    if (mismatches == 0) begin
      $display("tb_serial_line_editor_ring_unit OK");
    end else begin
      $display("tb_serial_line_editor_ring_unit NOT OK");
    end
    $finish;
  end

endmodule
